[hdl/assert_macros.svh]
// Assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

[hdl/pns_pkg.sv]
package pns_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_RIDGED = 2'd1,
		MODE_BILLOW = 2'd2,
		MODE_WARP   = 2'd3
	} mode_t;

	typedef enum logic {
		CFG_WARP_STRENGTH = 1'b0,
		CFG_WARP_OFFSET   = 1'b1
	} cfg_idx_t;

	localparam int SAMPLE_LAT   = 6;
	localparam int STRENGTH_W   = 24;
	localparam int OFFSET_W     = 8;
	localparam int OUT_W        = 19;
	localparam int OUT_MAX      = 262143;
	localparam int OUT_MIN      = -262144;
	localparam logic [STRENGTH_W-1:0] STRENGTH_RST = 24'd65536;

	localparam logic [7:0] PERM_ROM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180
	};

	function automatic logic [7:0] perm(input logic [7:0] idx);
		return PERM_ROM[idx];
	endfunction

endpackage

[hdl/pns_in_if.sv]
interface pns_in_if #(parameter int FRAC_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [1:0]             mode;
	logic [8+FRAC_BITS-1:0] x_coord;
	logic [8+FRAC_BITS-1:0] y_coord;

	modport source (output valid, mode, x_coord, y_coord, input ready);
	modport sink   (input valid, mode, x_coord, y_coord, output ready);
endinterface

[hdl/pns_out_if.sv]
interface pns_out_if;
	logic               valid;
	logic               ready;
	logic signed [18:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink   (input valid, noise_value, output ready);
endinterface

[hdl/pns_sampler.sv]
module pns_sampler #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [8+FRAC_BITS-1:0]        x_coord,
	input  logic [8+FRAC_BITS-1:0]        y_coord,
	output logic signed [FRAC_BITS+5:0]   noise
);
	import pns_pkg::*;

	localparam int F = FRAC_BITS;
	localparam int W = F + 6;
	typedef logic signed [W-1:0] fx_t;
	typedef logic signed [2*W-1:0] prod_t;

	localparam fx_t   ONE   = fx_t'(1) <<< F;
	localparam fx_t   HALF  = fx_t'(1) <<< (F - 1);
	localparam prod_t RND   = prod_t'(1) <<< (F - 1);

	function automatic fx_t mulq(input fx_t a, input fx_t b);
		prod_t p;
		p = prod_t'(a) * prod_t'(b) + RND;
		return fx_t'(p >>> F);
	endfunction

	function automatic longint mulc(input longint a, input longint b);
		return (a * b + (longint'(1) <<< (F - 1))) >>> F;
	endfunction

	function automatic longint fade_half();
		longint t;
		longint one;
		longint inner;
		t = longint'(1) <<< (F - 1);
		one = longint'(1) <<< F;
		inner = mulc(t, 6 * t - 15 * one) + 10 * one;
		return mulc(mulc(mulc(t, t), t), inner);
	endfunction

	localparam fx_t W_FADE = fx_t'(fade_half());

	function automatic fx_t grad(input logic [3:0] h, input fx_t x, input fx_t y,
			input fx_t z);
		fx_t u;
		fx_t v;
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic fx_t lerp(input fx_t a, input fx_t b, input fx_t t);
		return a + mulq(t, b - a);
	endfunction

	fx_t tx, ty;
	assign tx = fx_t'({{(W-F){1'b0}}, x_coord[F-1:0]});
	assign ty = fx_t'({{(W-F){1'b0}}, y_coord[F-1:0]});

	// stage 1
	logic [7:0] yi_s1, px_s1, px1_s1;
	fx_t fx_s1, fy_s1, ttx_s1, tty_s1, p1x_s1, p1y_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			yi_s1  <= y_coord[F+7:F];
			px_s1  <= perm(x_coord[F+7:F]);
			px1_s1 <= perm(x_coord[F+7:F] + 8'd1);
			fx_s1  <= tx;
			fy_s1  <= ty;
			ttx_s1 <= mulq(tx, tx);
			tty_s1 <= mulq(ty, ty);
			p1x_s1 <= mulq(tx, fx_t'(6 * tx - 15 * ONE));
			p1y_s1 <= mulq(ty, fx_t'(6 * ty - 15 * ONE));
		end
	end

	// stage 2
	logic [7:0] a_idx, b_idx;
	logic [7:0] aa_s2, ab_s2, ba_s2, bb_s2;
	fx_t fx_s2, fy_s2, t3x_s2, t3y_s2, inx_s2, iny_s2;

	assign a_idx = px_s1 + yi_s1;
	assign b_idx = px1_s1 + yi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2  <= perm(a_idx);
			ab_s2  <= perm(a_idx + 8'd1);
			ba_s2  <= perm(b_idx);
			bb_s2  <= perm(b_idx + 8'd1);
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			t3x_s2 <= mulq(ttx_s1, fx_s1);
			t3y_s2 <= mulq(tty_s1, fy_s1);
			inx_s2 <= fx_t'(p1x_s1 + 10 * ONE);
			iny_s2 <= fx_t'(p1y_s1 + 10 * ONE);
		end
	end

	// stage 3
	fx_t g_s3 [8];
	fx_t u_s3, v_s3;
	fx_t x1, y1, zl, zh;
	logic [7:0] h [8];

	assign x1 = fx_s2 - ONE;
	assign y1 = fy_s2 - ONE;
	assign zl = HALF;
	assign zh = HALF - ONE;

	always_comb begin
		h[0] = perm(aa_s2);
		h[1] = perm(ba_s2);
		h[2] = perm(ab_s2);
		h[3] = perm(bb_s2);
		h[4] = perm(aa_s2 + 8'd1);
		h[5] = perm(ba_s2 + 8'd1);
		h[6] = perm(ab_s2 + 8'd1);
		h[7] = perm(bb_s2 + 8'd1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s3[0] <= grad(h[0][3:0], fx_s2, fy_s2, zl);
			g_s3[1] <= grad(h[1][3:0], x1,    fy_s2, zl);
			g_s3[2] <= grad(h[2][3:0], fx_s2, y1,    zl);
			g_s3[3] <= grad(h[3][3:0], x1,    y1,    zl);
			g_s3[4] <= grad(h[4][3:0], fx_s2, fy_s2, zh);
			g_s3[5] <= grad(h[5][3:0], x1,    fy_s2, zh);
			g_s3[6] <= grad(h[6][3:0], fx_s2, y1,    zh);
			g_s3[7] <= grad(h[7][3:0], x1,    y1,    zh);
			u_s3    <= mulq(t3x_s2, inx_s2);
			v_s3    <= mulq(t3y_s2, iny_s2);
		end
	end

	// stage 4
	fx_t l_s4 [4];
	fx_t v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			l_s4[0] <= lerp(g_s3[0], g_s3[1], u_s3);
			l_s4[1] <= lerp(g_s3[2], g_s3[3], u_s3);
			l_s4[2] <= lerp(g_s3[4], g_s3[5], u_s3);
			l_s4[3] <= lerp(g_s3[6], g_s3[7], u_s3);
			v_s4    <= v_s3;
		end
	end

	// stage 5
	fx_t lo_s5, hi_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s5 <= lerp(l_s4[0], l_s4[1], v_s4);
			hi_s5 <= lerp(l_s4[2], l_s4[3], v_s4);
		end
	end

	// stage 6
	fx_t n_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6 <= lerp(lo_s5, hi_s5, W_FADE);
		end
	end

	assign noise = n_s6;

endmodule

[hdl/perlin_noise_sampler.sv]
// Improved 3D gradient noise sampled on the z = 0.5 slice, one sample per clock while not stalled.
// sample_in carries mode, x_coord and y_coord (unsigned, 8 integer bits and
// FRAC_BITS fraction bits, integer part wraps at 256); sample_out carries
// noise_value, signed Q3.16. Both are valid/ready channels; a beat moves when
// valid and ready are high at a rising edge.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_index
// (0 warp_strength, 1 warp_offset); write only while no sample is in flight.
// Pipeline, the same in every mode from an input beat to its result on
// sample_out: two noise units of six stages evaluate the warp probes (or
// the plain sample), one stage scales the warp, a third six-stage noise
// unit resamples, and the output register holds the result.
// Throughput: one sample per clock while sample_out is being taken.
// The whole pipeline advances together; when the receiver holds ready low
// with a result waiting, every stage holds and sample_in.ready drops.
// Reset clears all valid bits and sets warp_strength to 1.0 and
// warp_offset to 0.
`include "assert_macros.svh"

module perlin_noise_sampler #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [23:0]              cfg_wdata,
	pns_in_if.sink                   sample_in,
	pns_out_if.source                sample_out
);
	import pns_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int CW = 8 + F;
	localparam int W  = F + 6;
	localparam int L  = SAMPLE_LAT;
	typedef logic signed [W-1:0] fx_t;
	typedef logic signed [W+STRENGTH_W-1:0] sprod_t;
	localparam fx_t    ONE = fx_t'(1) <<< F;
	localparam sprod_t RND = sprod_t'(1) <<< (F - 1);

	logic signed [STRENGTH_W-1:0] warp_strength_q;
	logic [OFFSET_W-1:0]          warp_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warp_strength_q <= STRENGTH_RST;
			warp_offset_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WARP_STRENGTH: warp_strength_q <= cfg_wdata[STRENGTH_W-1:0];
				CFG_WARP_OFFSET:   warp_offset_q   <= cfg_wdata[OFFSET_W-1:0];
				default:           warp_offset_q   <= warp_offset_q;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || sample_out.ready;
	assign sample_in.ready = en;

	// first pass: warp probes, or the plain sample in sampler a
	logic          is_warp_in;
	logic [CW-1:0] off_in;
	logic [CW-1:0] xa, yb;
	fx_t           na, nb;

	assign is_warp_in = (sample_in.mode == MODE_WARP);
	assign off_in = is_warp_in ? {warp_offset_q, {F{1'b0}}} : '0;
	assign xa = sample_in.x_coord + off_in;
	assign yb = sample_in.y_coord + off_in;

	pns_sampler #(.FRAC_BITS(F)) u_sampler_a (
		.clk(clk), .en(en), .x_coord(xa), .y_coord(sample_in.y_coord), .noise(na));
	pns_sampler #(.FRAC_BITS(F)) u_sampler_b (
		.clk(clk), .en(en), .x_coord(sample_in.x_coord), .y_coord(yb), .noise(nb));

	logic          vld_sa [L];
	logic [1:0]    mode_sa [L];
	logic [CW-1:0] x_sa [L];
	logic [CW-1:0] y_sa [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) vld_sa[i] <= 1'b0;
		end else if (en) begin
			vld_sa[0] <= sample_in.valid;
			for (int i = 1; i < L; i++) vld_sa[i] <= vld_sa[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_sa[0] <= sample_in.mode;
			x_sa[0]    <= sample_in.x_coord;
			y_sa[0]    <= sample_in.y_coord;
			for (int i = 1; i < L; i++) begin
				mode_sa[i] <= mode_sa[i-1];
				x_sa[i]    <= x_sa[i-1];
				y_sa[i]    <= y_sa[i-1];
			end
		end
	end

	// warp scaling and shaped result for the other modes
	fx_t    n_abs, r_shape;
	sprod_t pdx, pdy;

	assign n_abs = (na < 0) ? -na : na;
	assign pdx = sprod_t'(na) * sprod_t'(warp_strength_q) + RND;
	assign pdy = sprod_t'(nb) * sprod_t'(warp_strength_q) + RND;

	always_comb begin
		case (mode_sa[L-1])
			MODE_RIDGED: r_shape = ONE - n_abs;
			MODE_BILLOW: r_shape = (n_abs <<< 1) - ONE;
			default:     r_shape = na;
		endcase
	end

	logic          vld_s7;
	logic [1:0]    mode_s7;
	logic [CW-1:0] x_s7, y_s7, dx_s7, dy_s7;
	fx_t           r_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_sa[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s7 <= mode_sa[L-1];
			x_s7    <= x_sa[L-1];
			y_s7    <= y_sa[L-1];
			dx_s7   <= CW'(pdx >>> F);
			dy_s7   <= CW'(pdy >>> F);
			r_s7    <= r_shape;
		end
	end

	// second pass at the displaced point
	logic [CW-1:0] xc, yc;
	fx_t           nc;

	assign xc = x_s7 + dx_s7;
	assign yc = y_s7 + dy_s7;

	pns_sampler #(.FRAC_BITS(F)) u_sampler_c (
		.clk(clk), .en(en), .x_coord(xc), .y_coord(yc), .noise(nc));

	logic       vld_sc [L];
	logic [1:0] mode_sc [L];
	fx_t        r_sc [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) vld_sc[i] <= 1'b0;
		end else if (en) begin
			vld_sc[0] <= vld_s7;
			for (int i = 1; i < L; i++) vld_sc[i] <= vld_sc[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_sc[0] <= mode_s7;
			r_sc[0]    <= r_s7;
			for (int i = 1; i < L; i++) begin
				mode_sc[i] <= mode_sc[i-1];
				r_sc[i]    <= r_sc[i-1];
			end
		end
	end

	// select and saturate
	logic signed [31:0]        r_wide;
	logic signed [OUT_W-1:0]   r_sat;
	logic signed [OUT_W-1:0]   noise_q;

	assign r_wide = 32'(signed'((mode_sc[L-1] == MODE_WARP) ? nc : r_sc[L-1]));

	always_comb begin
		if (r_wide > OUT_MAX) r_sat = OUT_W'(OUT_MAX);
		else if (r_wide < OUT_MIN) r_sat = OUT_W'(OUT_MIN);
		else r_sat = r_wide[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_sc[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			noise_q <= r_sat;
		end
	end

	assign sample_out.valid       = out_valid_q;
	assign sample_out.noise_value = noise_q;

	`ASSERT_NEXT(a_stall_holds, !en, $stable(vld_s7) && $stable(vld_sc[0]))
	`ASSERT_NEXT(a_warp_flow, en && vld_sa[L-1], vld_s7)
	`ASSERT_NEXT(a_cfg_offset, cfg_we && cfg_index == CFG_WARP_OFFSET,
		warp_offset_q == $past(cfg_wdata[OFFSET_W-1:0]))
	`ASSERT_IMPL(a_ready_on_empty, !out_valid_q, sample_in.ready)

endmodule
